// File: design/extent_page_allocator_top_macros.svh
// assertion macros for the extent allocator rtl
// expects clk and arst_n in the scope of the module that uses them
`ifndef EXTENT_PAGE_ALLOCATOR_TOP_MACROS_SVH
`define EXTENT_PAGE_ALLOCATOR_TOP_MACROS_SVH

// property checked at every clock edge outside reset
`define EPA_CHECK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);

// consequent must hold in the cycle after the antecedent
`define EPA_CHECK_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: design/epa_pkg.sv
// types and codes of the extent page allocator
// used by the controller, the datapath and the top level
package epa_pkg;

	localparam logic [3:0] KIND_UNSET   = 4'd0;
	localparam logic [3:0] KIND_FREE    = 4'd5;
	localparam logic [3:0] KIND_ALLOC   = 4'd8;
	localparam logic [3:0] KIND_RESERVE = 4'd9;
	localparam logic [3:0] KIND_LIMIT   = 4'd10;

	localparam logic [2:0] OP_ADD       = 3'd0;
	localparam logic [2:0] OP_MARK      = 3'd1;
	localparam logic [2:0] OP_ALLOC     = 3'd2;
	localparam logic [2:0] OP_ALLOC_RES = 3'd3;
	localparam logic [2:0] OP_FREE      = 3'd4;

	typedef enum logic [2:0] {
		ST_OK          = 3'd0,
		ST_NO_BLOCK    = 3'd1,
		ST_MID_BLOCK   = 3'd2,
		ST_DOUBLE_FREE = 3'd3,
		ST_NO_SPACE    = 3'd4,
		ST_NO_RESERVE  = 3'd5,
		ST_TABLE_FULL  = 3'd6
	} st_code_t;

	typedef enum logic [2:0] {
		SC_READ, SC_CONTAIN, SC_PREV, SC_SEEK_L, SC_SEEK0, SC_UNSET, SC_RESERVE, SC_RELEASE
	} sc_mode_t;

	typedef enum logic [4:0] {
		DP_NOP, DP_LOAD, DP_SCAN, DP_SAVE_P, DP_PUT_MAIN, DP_PUT_TAIL,
		DP_W_E_GROW_PL, DP_W_E_GROW_L, DP_W_PUT_NEW, DP_W_P_SHRINK, DP_W_P_UNSET,
		DP_W_P_SET, DP_W_P_HEAD, DP_W_P_FREE, DP_W_E_UNSET, DP_W_P_GROW_E,
		DP_ALLOC_HIT, DP_RES_HIT, DP_SET_STATUS, DP_DROP, DP_FINISH
	} dp_op_t;

	typedef struct packed {
		dp_op_t   op;
		sc_mode_t mode;
		st_code_t code;
	} dp_cmd_t;

	typedef struct packed {
		logic clearing;
		logic busy;
		logic hit;
		logic put_skip;
		logic put_free;
		logic e_free;
		logic e_len_ge_l;
		logic e_extend;
		logic prev_ok;
		logic b_eq_pbase;
		logic b_nonzero;
		logic p_len_gt_l;
		logic p_free;
		logic rel_merge;
		logic kind_ok;
		logic out_free;
	} dp_stat_t;

endpackage

// File: design/epa_ram.sv
// generic single write port ram with registered read
// no dependencies
module epa_ram #(
	parameter int W = 8,
	parameter int D = 16
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic [$clog2(D)-1:0] waddr,
	input  logic [W-1:0]         wdata,
	input  logic [$clog2(D)-1:0] raddr,
	output logic [W-1:0]         rdata
);

	logic [W-1:0] mem [D];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end

endmodule

// File: design/epa_datapath.sv
// datapath: slot table ram, scan engine, working registers and response register
// depends on epa_pkg, epa_ram and the assertion macro header
`include "extent_page_allocator_top_macros.svh"

module epa_datapath
	import epa_pkg::*;
#(
	parameter int SLOTS = 64,
	parameter int P     = 24
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic [P-1:0]  base_page,
	input  logic [P-1:0]  length,
	input  logic [3:0]    kind,
	input  dp_cmd_t       cmd,
	output dp_stat_t      st,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	output logic [P-1:0]  result_page,
	output logic [2:0]    status
);

	localparam int IW = $clog2(SLOTS);
	localparam int CW = IW + 1;
	localparam int EW = 2 * P + 5;
	localparam logic [IW-1:0] LAST = IW'(SLOTS - 1);

	// table entry: {kind, base, length}
	logic          we;
	logic [IW-1:0] waddr, raddr;
	logic [EW-1:0] wdata, rdata;
	logic [3:0]    r_kind;
	logic [P-1:0]  r_base;
	logic [P:0]    r_len;

	logic [P:0]    b_q, l_q, pb_q, pl_q;
	logic [3:0]    f_q, pf_q, e_kind_q, p_kind_q;
	logic [IW-1:0] fs_q, e_idx_q, p_idx_q, ridx_q;
	logic [P-1:0]  e_base_q, p_base_q, page_q;
	logic [P:0]    e_len_q, p_len_q;
	logic          skip_q, drop_q, hit_q, busy_q, pend_q, clr_q;
	st_code_t      code_q;
	sc_mode_t      mode_q;
	logic [CW-1:0] cnt_q, clr_cnt_q;
	logic          rsp_valid_q;
	logic [P-1:0]  out_page_q;
	st_code_t      out_status_q;

	logic [P+1:0]  r_end, bw, lw, e_end, p_end;
	logic          match;
	logic [P:0]    sb, sl, room, pl_clip;
	logic [3:0]    sf;
	logic          put_op, skip_d;

	epa_ram #(.W(EW), .D(SLOTS)) u_table (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata)
	);

	assign r_kind = rdata[EW-1 -: 4];
	assign r_base = rdata[2*P : P+1];
	assign r_len  = rdata[P:0];

	assign raddr = (mode_q == SC_READ) ? fs_q : cnt_q[IW-1:0];

	assign r_end = {2'b00, r_base} + {1'b0, r_len};
	assign bw    = {1'b0, b_q};
	assign lw    = {1'b0, l_q};
	assign e_end = {2'b00, e_base_q} + {1'b0, e_len_q};
	assign p_end = {2'b00, p_base_q} + {1'b0, p_len_q};

	always_comb begin
		case (mode_q)
			SC_READ:    match = 1'b1;
			SC_CONTAIN: match = (r_kind != KIND_UNSET) && (bw >= {2'b00, r_base})
				&& ((bw + lw) <= r_end);
			SC_PREV:    match = (r_kind != KIND_UNSET) && ((bw - (P+2)'(1)) >= {2'b00, r_base})
				&& (bw <= r_end);
			SC_SEEK_L:  match = (r_kind == KIND_FREE) && (r_len >= l_q);
			SC_SEEK0:   match = (r_kind == KIND_FREE);
			SC_UNSET:   match = (r_kind == KIND_UNSET);
			SC_RESERVE: match = (r_kind == KIND_RESERVE) && (r_len >= l_q);
			SC_RELEASE: match = (r_kind != KIND_UNSET) && ({2'b00, r_base} <= bw) && (bw < r_end);
			default:    match = 1'b0;
		endcase
	end

	// put setup: main range or the tail left after a split
	always_comb begin
		put_op = 1'b1;
		case (cmd.op)
			DP_PUT_MAIN: begin
				sb = b_q;
				sl = l_q;
				sf = f_q;
			end
			DP_PUT_TAIL: begin
				sb = (P+1)'(bw + lw);
				sl = (P+1)'(p_end - (bw + lw));
				sf = p_kind_q;
			end
			default: begin
				sb = b_q;
				sl = l_q;
				sf = f_q;
				put_op = 1'b0;
			end
		endcase
		room    = {1'b1, {P{1'b0}}} - sb;
		pl_clip = (sl > room) ? room : sl;
		skip_d  = (sl == '0) || (sf == KIND_UNSET) || (sf >= KIND_LIMIT) || sb[P];
	end

	// single write port, clearing pass first
	always_comb begin
		we    = 1'b1;
		waddr = p_idx_q;
		wdata = {p_kind_q, p_base_q, p_len_q};
		if (clr_q) begin
			waddr = clr_cnt_q[IW-1:0];
			wdata = {KIND_UNSET, {P{1'b0}}, {(P+1){1'b0}}};
		end else begin
			case (cmd.op)
				DP_W_E_GROW_PL: begin
					waddr = e_idx_q;
					wdata = {e_kind_q, e_base_q, (P+1)'(e_len_q + pl_q)};
				end
				DP_W_E_GROW_L: begin
					waddr = e_idx_q;
					wdata = {e_kind_q, e_base_q, (P+1)'(e_len_q + l_q)};
				end
				DP_W_PUT_NEW: begin
					waddr = e_idx_q;
					wdata = {pf_q, pb_q[P-1:0], pl_q};
				end
				DP_W_P_SHRINK:
					wdata = {p_kind_q, P'(p_base_q + l_q[P-1:0]), (P+1)'(p_len_q - l_q)};
				DP_W_P_UNSET: wdata = {KIND_UNSET, p_base_q, p_len_q};
				DP_W_P_SET:   wdata = {f_q, p_base_q, l_q};
				DP_W_P_HEAD:  wdata = {p_kind_q, p_base_q, (P+1)'(b_q - {1'b0, p_base_q})};
				DP_W_P_FREE:  wdata = {KIND_FREE, p_base_q, p_len_q};
				DP_W_E_UNSET: begin
					waddr = e_idx_q;
					wdata = {KIND_UNSET, e_base_q, e_len_q};
				end
				DP_W_P_GROW_E: wdata = {KIND_FREE, p_base_q, (P+1)'(p_len_q + e_len_q)};
				default: we = 1'b0;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q     <= 1'b1;
			clr_cnt_q <= '0;
			busy_q    <= 1'b0;
			pend_q    <= 1'b0;
			hit_q     <= 1'b0;
			cnt_q     <= '0;
			mode_q    <= SC_READ;
			fs_q      <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (clr_q) begin
				clr_cnt_q <= clr_cnt_q + CW'(1);
				if (clr_cnt_q[IW-1:0] == LAST)
					clr_q <= 1'b0;
			end
			if (cmd.op == DP_SCAN) begin
				busy_q <= 1'b1;
				pend_q <= 1'b0;
				hit_q  <= 1'b0;
				cnt_q  <= '0;
				mode_q <= cmd.mode;
			end else if (busy_q) begin
				pend_q <= (cnt_q < CW'(SLOTS));
				if (cnt_q < CW'(SLOTS))
					cnt_q <= cnt_q + CW'(1);
				if (pend_q && match) begin
					busy_q <= 1'b0;
					hit_q  <= 1'b1;
					if (mode_q == SC_SEEK_L || mode_q == SC_SEEK0)
						fs_q <= ridx_q;
				end else if (pend_q && ridx_q == LAST) begin
					busy_q <= 1'b0;
				end
			end
			if (cmd.op == DP_FINISH)
				rsp_valid_q <= 1'b1;
			else if (rsp_ready)
				rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		ridx_q <= raddr;
		if (busy_q && pend_q && match) begin
			e_idx_q  <= ridx_q;
			e_kind_q <= r_kind;
			e_base_q <= r_base;
			e_len_q  <= r_len;
		end
		if (put_op) begin
			pb_q   <= sb;
			pl_q   <= pl_clip;
			pf_q   <= sf;
			skip_q <= skip_d;
		end
		case (cmd.op)
			DP_LOAD: begin
				b_q    <= {1'b0, base_page};
				l_q    <= {1'b0, length};
				f_q    <= kind;
				page_q <= '0;
				code_q <= ST_OK;
				drop_q <= 1'b0;
			end
			DP_SAVE_P: begin
				p_idx_q  <= e_idx_q;
				p_kind_q <= e_kind_q;
				p_base_q <= e_base_q;
				p_len_q  <= e_len_q;
			end
			DP_ALLOC_HIT: begin
				page_q <= e_base_q;
				b_q    <= {1'b0, e_base_q};
				f_q    <= KIND_ALLOC;
			end
			DP_RES_HIT: begin
				page_q <= e_base_q;
				b_q    <= {1'b0, e_base_q};
			end
			DP_SET_STATUS: code_q <= cmd.code;
			DP_DROP:       drop_q <= 1'b1;
			DP_FINISH: begin
				out_page_q   <= page_q;
				out_status_q <= (drop_q && code_q == ST_OK) ? ST_TABLE_FULL : code_q;
			end
			default: ;
		endcase
	end

	always_comb begin
		st.clearing   = clr_q;
		st.busy       = busy_q;
		st.hit        = hit_q;
		st.put_skip   = skip_q;
		st.put_free   = (pf_q == KIND_FREE);
		st.e_free     = (e_kind_q == KIND_FREE);
		st.e_len_ge_l = (e_len_q >= l_q);
		st.e_extend   = (e_kind_q == KIND_FREE) && (e_end == {1'b0, pb_q});
		st.prev_ok    = hit_q && (e_end == bw) && (e_kind_q == f_q);
		st.b_eq_pbase = (b_q == {1'b0, p_base_q});
		st.b_nonzero  = (b_q != '0);
		st.p_len_gt_l = (p_len_q > l_q);
		st.p_free     = (p_kind_q == KIND_FREE);
		st.rel_merge  = (e_kind_q == KIND_FREE) && (e_base_q > p_base_q)
			&& (p_end == {2'b00, e_base_q});
		st.kind_ok    = (f_q != KIND_UNSET) && (f_q < KIND_LIMIT);
		st.out_free   = !rsp_valid_q || rsp_ready;
	end

	assign rsp_valid   = rsp_valid_q;
	assign result_page = out_page_q;
	assign status      = out_status_q;

	`EPA_CHECK(a_no_write_in_scan, (busy_q |-> !we), "table write during a scan")
	`EPA_CHECK(a_no_scan_in_clear, (clr_q |-> !busy_q), "scan during clearing pass")
	`EPA_CHECK(a_fs_range, (fs_q <= LAST), "free slot index out of range")
	`EPA_CHECK_NEXT(a_scan_ends, busy_q && pend_q && ridx_q == LAST, !busy_q, "scan ran past last slot")

endmodule

// File: design/epa_ctrl.sv
// controller: sequences table scans and writes for each request
// depends on epa_pkg
module epa_ctrl
	import epa_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       req_valid,
	output logic       req_ready,
	input  logic [2:0] operation,
	input  dp_stat_t   st,
	output dp_cmd_t    cmd
);

	typedef enum logic [30:0] {
		S_CLEAR    = 31'b1 << 0,
		S_IDLE     = 31'b1 << 1,
		S_DISPATCH = 31'b1 << 2,
		S_PUT_MAIN = 31'b1 << 3,
		S_PUT_TAIL = 31'b1 << 4,
		S_PUT_CHK  = 31'b1 << 5,
		S_PUT_FS   = 31'b1 << 6,
		S_PUT_GROW = 31'b1 << 7,
		S_PUT_SCAN = 31'b1 << 8,
		S_PUT_NEW  = 31'b1 << 9,
		S_RT_SCAN  = 31'b1 << 10,
		S_RT_CASE  = 31'b1 << 11,
		S_RT_PREV  = 31'b1 << 12,
		S_RT_MERGE = 31'b1 << 13,
		S_RT_TRIM  = 31'b1 << 14,
		S_RT_NOPREV = 31'b1 << 15,
		S_RT_HEAD  = 31'b1 << 16,
		S_FIX      = 31'b1 << 17,
		S_FIX_SEEK = 31'b1 << 18,
		S_TF_RD    = 31'b1 << 19,
		S_TF_SEEK1 = 31'b1 << 20,
		S_TF_SEEK2 = 31'b1 << 21,
		S_TF_SEEK0 = 31'b1 << 22,
		S_TF_TAKE  = 31'b1 << 23,
		S_RES_SCAN = 31'b1 << 24,
		S_REL_SCAN = 31'b1 << 25,
		S_REL_CHK  = 31'b1 << 26,
		S_REL_FS   = 31'b1 << 27,
		S_REL_M1   = 31'b1 << 28,
		S_REL_M2   = 31'b1 << 29,
		S_FINISH   = 31'b1 << 30
	} state_t;

	state_t     state_q, state_d, ret_q, ret_d;
	logic [2:0] op_q, op_d;
	logic       launched_q, is_scan, scan_done;

	assign scan_done = launched_q && !st.busy;

	always_comb begin
		cmd       = '{op: DP_NOP, mode: SC_READ, code: ST_OK};
		state_d   = state_q;
		ret_d     = ret_q;
		op_d      = op_q;
		is_scan   = 1'b0;
		req_ready = 1'b0;
		case (state_q)
			S_CLEAR: if (!st.clearing) state_d = S_IDLE;
			S_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.op  = DP_LOAD;
					op_d    = operation;
					state_d = S_DISPATCH;
				end
			end
			S_DISPATCH: begin
				case (op_q)
					OP_ADD: begin
						ret_d   = S_FINISH;
						state_d = S_PUT_MAIN;
					end
					OP_MARK:  state_d = st.kind_ok ? S_RT_SCAN : S_FINISH;
					OP_ALLOC: state_d = S_TF_RD;
					OP_ALLOC_RES: begin
						if (st.kind_ok) begin
							state_d = S_RES_SCAN;
						end else begin
							cmd.op   = DP_SET_STATUS;
							cmd.code = ST_NO_RESERVE;
							state_d  = S_FINISH;
						end
					end
					OP_FREE: state_d = S_REL_SCAN;
					default: state_d = S_FINISH;
				endcase
			end
			S_PUT_MAIN: begin
				cmd.op  = DP_PUT_MAIN;
				state_d = S_PUT_CHK;
			end
			S_PUT_TAIL: begin
				cmd.op  = DP_PUT_TAIL;
				ret_d   = S_RT_HEAD;
				state_d = S_PUT_CHK;
			end
			S_PUT_CHK: begin
				if (st.put_skip)
					state_d = ret_q;
				else if (st.put_free)
					state_d = S_PUT_FS;
				else
					state_d = S_PUT_SCAN;
			end
			S_PUT_FS: begin
				is_scan = 1'b1;
				if (scan_done) state_d = st.e_extend ? S_PUT_GROW : S_PUT_SCAN;
			end
			S_PUT_GROW: begin
				cmd.op  = DP_W_E_GROW_PL;
				state_d = ret_q;
			end
			S_PUT_SCAN: begin
				is_scan  = 1'b1;
				cmd.mode = SC_UNSET;
				if (scan_done) begin
					if (st.hit) begin
						state_d = S_PUT_NEW;
					end else begin
						cmd.op  = DP_DROP;
						state_d = ret_q;
					end
				end
			end
			S_PUT_NEW: begin
				cmd.op  = DP_W_PUT_NEW;
				state_d = ret_q;
			end
			S_RT_SCAN: begin
				is_scan  = 1'b1;
				cmd.mode = SC_CONTAIN;
				if (scan_done) begin
					if (st.hit) begin
						cmd.op  = DP_SAVE_P;
						state_d = S_RT_CASE;
					end else begin
						ret_d   = S_FIX;
						state_d = S_PUT_MAIN;
					end
				end
			end
			S_RT_CASE: begin
				if (st.b_eq_pbase) begin
					state_d = st.b_nonzero ? S_RT_PREV : S_RT_NOPREV;
				end else begin
					// split: new range, then the tail, then cut the head
					ret_d   = S_PUT_TAIL;
					state_d = S_PUT_MAIN;
				end
			end
			S_RT_PREV: begin
				is_scan  = 1'b1;
				cmd.mode = SC_PREV;
				if (scan_done) state_d = st.prev_ok ? S_RT_MERGE : S_RT_NOPREV;
			end
			S_RT_MERGE: begin
				cmd.op  = DP_W_E_GROW_L;
				state_d = S_RT_TRIM;
			end
			S_RT_TRIM: begin
				cmd.op  = st.p_len_gt_l ? DP_W_P_SHRINK : DP_W_P_UNSET;
				state_d = S_FIX;
			end
			S_RT_NOPREV: begin
				if (st.p_len_gt_l) begin
					cmd.op  = DP_W_P_SHRINK;
					ret_d   = S_FIX;
					state_d = S_PUT_MAIN;
				end else begin
					cmd.op  = DP_W_P_SET;
					state_d = S_FIX;
				end
			end
			S_RT_HEAD: begin
				cmd.op  = DP_W_P_HEAD;
				state_d = S_FIX;
			end
			S_FIX: begin
				is_scan = 1'b1;
				if (scan_done) state_d = st.e_free ? S_FINISH : S_FIX_SEEK;
			end
			S_FIX_SEEK: begin
				is_scan  = 1'b1;
				cmd.mode = SC_SEEK0;
				if (scan_done) state_d = S_FINISH;
			end
			S_TF_RD: begin
				is_scan = 1'b1;
				if (scan_done) begin
					if (!st.e_free)
						state_d = S_TF_SEEK1;
					else if (st.e_len_ge_l)
						state_d = S_TF_TAKE;
					else
						state_d = S_TF_SEEK2;
				end
			end
			S_TF_SEEK1: begin
				is_scan  = 1'b1;
				cmd.mode = SC_SEEK_L;
				if (scan_done) begin
					if (st.hit) begin
						state_d = S_TF_TAKE;
					end else begin
						cmd.op   = DP_SET_STATUS;
						cmd.code = ST_NO_SPACE;
						state_d  = S_FINISH;
					end
				end
			end
			S_TF_SEEK2: begin
				is_scan  = 1'b1;
				cmd.mode = SC_SEEK_L;
				if (scan_done) state_d = st.hit ? S_TF_TAKE : S_TF_SEEK0;
			end
			S_TF_SEEK0: begin
				is_scan  = 1'b1;
				cmd.mode = SC_SEEK0;
				if (scan_done) begin
					cmd.op   = DP_SET_STATUS;
					cmd.code = ST_NO_SPACE;
					state_d  = S_FINISH;
				end
			end
			S_TF_TAKE: begin
				cmd.op  = DP_ALLOC_HIT;
				state_d = S_RT_SCAN;
			end
			S_RES_SCAN: begin
				is_scan  = 1'b1;
				cmd.mode = SC_RESERVE;
				if (scan_done) begin
					if (st.hit) begin
						cmd.op  = DP_RES_HIT;
						state_d = S_RT_SCAN;
					end else begin
						cmd.op   = DP_SET_STATUS;
						cmd.code = ST_NO_RESERVE;
						state_d  = S_FINISH;
					end
				end
			end
			S_REL_SCAN: begin
				is_scan  = 1'b1;
				cmd.mode = SC_RELEASE;
				if (scan_done) begin
					if (st.hit) begin
						cmd.op  = DP_SAVE_P;
						state_d = S_REL_CHK;
					end else begin
						cmd.op   = DP_SET_STATUS;
						cmd.code = ST_NO_BLOCK;
						state_d  = S_FINISH;
					end
				end
			end
			S_REL_CHK: begin
				if (!st.b_eq_pbase) begin
					cmd.op   = DP_SET_STATUS;
					cmd.code = ST_MID_BLOCK;
					state_d  = S_FINISH;
				end else if (st.p_free) begin
					cmd.op   = DP_SET_STATUS;
					cmd.code = ST_DOUBLE_FREE;
					state_d  = S_FINISH;
				end else begin
					cmd.op  = DP_W_P_FREE;
					state_d = S_REL_FS;
				end
			end
			S_REL_FS: begin
				is_scan = 1'b1;
				if (scan_done) state_d = st.rel_merge ? S_REL_M1 : S_FINISH;
			end
			S_REL_M1: begin
				cmd.op  = DP_W_E_UNSET;
				state_d = S_REL_M2;
			end
			S_REL_M2: begin
				cmd.op  = DP_W_P_GROW_E;
				state_d = S_FINISH;
			end
			S_FINISH: begin
				if (st.out_free) begin
					cmd.op  = DP_FINISH;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
		if (is_scan && !launched_q)
			cmd.op = DP_SCAN;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_CLEAR;
			ret_q      <= S_FINISH;
			op_q       <= OP_ADD;
			launched_q <= 1'b0;
		end else begin
			state_q    <= state_d;
			ret_q      <= ret_d;
			op_q       <= op_d;
			launched_q <= is_scan && (!launched_q || st.busy);
		end
	end

endmodule

// File: design/extent_page_allocator_top.sv
// Extent page allocator over a table of SLOTS extents.
// Requests enter on req_valid/req_ready with operation, base_page, length and
// kind; one response per request leaves on rsp_valid/rsp_ready with
// result_page and status. Operations: add, mark, allocate (from the cached
// free extent if it fits, else first-fit), allocate from reserve, free.
// After reset the table is cleared by a pass over all SLOTS entries during
// which req_ready stays low.
// One request is worked at a time. How long it takes is set by walks of the
// table through the single read port of the slot ram: a request makes none
// to seven of them, plus write and decision steps.
// The response sits in an output register; a new request is taken while
// it waits. If the receiver stalls with a response still pending, the next
// finished request holds in its final state until the register frees up.
// depends on epa_pkg, epa_ctrl and epa_datapath
module extent_page_allocator_top
	import epa_pkg::*;
#(
	parameter int SLOTS            = 64,
	parameter int PAGE_NUMBER_BITS = 24
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        req_valid,
	output logic                        req_ready,
	input  logic [2:0]                  operation,
	input  logic [PAGE_NUMBER_BITS-1:0] base_page,
	input  logic [PAGE_NUMBER_BITS-1:0] length,
	input  logic [3:0]                  kind,
	output logic                        rsp_valid,
	input  logic                        rsp_ready,
	output logic [PAGE_NUMBER_BITS-1:0] result_page,
	output logic [2:0]                  status
);

	dp_cmd_t  cmd;
	dp_stat_t st;

	epa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.operation(operation),
		.st       (st),
		.cmd      (cmd)
	);

	epa_datapath #(.SLOTS(SLOTS), .P(PAGE_NUMBER_BITS)) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.base_page  (base_page),
		.length     (length),
		.kind       (kind),
		.cmd        (cmd),
		.st         (st),
		.rsp_valid  (rsp_valid),
		.rsp_ready  (rsp_ready),
		.result_page(result_page),
		.status     (status)
	);

endmodule

// File: tb/extent_page_allocator_top_tb.sv
// self-checking testbench for extent_page_allocator_top
// predicts every response with an in-bench extent table; needs epa_pkg and dut
`timescale 1ns / 100ps

module extent_page_allocator_top_tb;
	import epa_pkg::*;

	localparam int SLOTS = 64;
	localparam int PNB = 24;
	localparam longint unsigned PSPACE = 64'd1 << PNB;
	localparam logic [2:0] OP_SPARE = 3'd7;
	localparam int RAND_ITEMS = 1730;
	localparam int STALL_LIMIT = 20000;
	localparam logic [PNB-1:0] PMAX = {PNB{1'b1}};

	typedef struct {
		logic [PNB-1:0] page;
		st_code_t       st;
	} rsp_t;

	typedef struct {
		logic [2:0]     op;
		logic [PNB-1:0] b;
		logic [PNB-1:0] l;
		logic [3:0]     k;
		bit             typed;
		logic [PNB-1:0] page;
		st_code_t       st;
	} dir_row_t;

	logic clk, arst_n;
	logic req_valid, req_ready, rsp_valid, rsp_ready;
	logic [2:0] operation;
	logic [PNB-1:0] base_page, length, result_page;
	logic [3:0] kind;
	logic [2:0] status;

	// predictor state
	logic [3:0] ext_kind[SLOTS];
	longint unsigned ext_base[SLOTS];
	longint unsigned ext_len[SLOTS];
	int cur_free;
	bit ext_dropped;

	rsp_t pending_rsp[$];
	logic [PNB-1:0] taken_pages[$];
	int errors = 0;
	int sent = 0;
	int idle_cnt = 0;
	int phase = 0;
	int hold_left = 0;
	bit hold_done = 0;

	extent_page_allocator_top u_top (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_ready(req_ready),
		.operation(operation), .base_page(base_page), .length(length), .kind(kind),
		.rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
		.result_page(result_page), .status(status)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic longint unsigned ext_end(int i);
		return ext_base[i] + ext_len[i];
	endfunction

	function automatic int find_covering(longint unsigned b, longint unsigned l);
		longint unsigned e;
		e = b + l;
		for (int i = 0; i < SLOTS; i++)
			if (ext_kind[i] != KIND_UNSET && b >= ext_base[i] && e <= ext_end(i))
				return i;
		return SLOTS;
	endfunction

	function automatic void seek_free(longint unsigned l);
		for (int i = 0; i < SLOTS; i++)
			if (ext_kind[i] == KIND_FREE && ext_len[i] >= l) begin
				cur_free = i;
				return;
			end
	endfunction

	function automatic void put_extent(longint unsigned b, longint unsigned l, logic [3:0] k);
		if (l == 0 || k == KIND_UNSET || k >= KIND_LIMIT || b >= PSPACE)
			return;
		if (l > PSPACE - b)
			l = PSPACE - b;
		if (k == KIND_FREE && ext_kind[cur_free] == KIND_FREE && ext_end(cur_free) == b) begin
			ext_len[cur_free] += l;
			return;
		end
		for (int i = 0; i < SLOTS; i++)
			if (ext_kind[i] == KIND_UNSET) begin
				ext_base[i] = b;
				ext_len[i] = l;
				ext_kind[i] = k;
				return;
			end
		ext_dropped = 1;
	endfunction

	function automatic void retype(longint unsigned b, longint unsigned l, logic [3:0] k);
		int p, prev;
		longint unsigned head;
		p = find_covering(b, l);
		if (p == SLOTS) begin
			put_extent(b, l, k);
		end else if (b == ext_base[p]) begin
			prev = SLOTS;
			if (b >= 1)
				prev = find_covering(b - 1, 1);
			if (prev != SLOTS && ext_end(prev) == b && ext_kind[prev] == k) begin
				ext_len[prev] += l;
				if (ext_len[p] > l) begin
					ext_len[p] -= l;
					ext_base[p] += l;
				end else begin
					ext_kind[p] = KIND_UNSET;
				end
			end else if (ext_len[p] > l) begin
				ext_len[p] -= l;
				ext_base[p] += l;
				put_extent(b, l, k);
			end else begin
				ext_len[p] = l;
				ext_kind[p] = k;
			end
		end else begin
			// split: head stays in place, tail gets the old kind
			head = b - ext_base[p];
			put_extent(b, l, k);
			put_extent(b + l, ext_len[p] - (l + head), ext_kind[p]);
			ext_len[p] = head;
		end
		if (ext_kind[cur_free] != KIND_FREE)
			seek_free(0);
	endfunction

	function automatic bit take_free(longint unsigned l, output longint unsigned page);
		page = 0;
		if (ext_kind[cur_free] != KIND_FREE) begin
			seek_free(l);
			if (ext_kind[cur_free] != KIND_FREE)
				return 0;
		end
		if (ext_len[cur_free] < l) begin
			seek_free(l);
			if (ext_kind[cur_free] != KIND_FREE || ext_len[cur_free] < l) begin
				seek_free(0);
				return 0;
			end
		end
		page = ext_base[cur_free];
		retype(page, l, KIND_ALLOC);
		return 1;
	endfunction

	function automatic st_code_t release_block(longint unsigned b);
		int p, fs;
		p = SLOTS;
		for (int i = 0; i < SLOTS; i++)
			if (ext_kind[i] != KIND_UNSET && ext_base[i] <= b && b < ext_end(i)) begin
				p = i;
				break;
			end
		if (p == SLOTS)
			return ST_NO_BLOCK;
		if (ext_base[p] != b)
			return ST_MID_BLOCK;
		if (ext_kind[p] == KIND_FREE)
			return ST_DOUBLE_FREE;
		ext_kind[p] = KIND_FREE;
		fs = cur_free;
		if (ext_kind[fs] == KIND_FREE && ext_base[fs] > ext_base[p]
				&& ext_end(p) == ext_base[fs]) begin
			ext_kind[fs] = KIND_UNSET;
			ext_len[p] += ext_len[fs];
		end
		return ST_OK;
	endfunction

	function automatic rsp_t predict_rsp(logic [2:0] op, logic [PNB-1:0] b, logic [PNB-1:0] l,
			logic [3:0] k);
		rsp_t r;
		longint unsigned page;
		int te;
		bit kind_ok;
		page = 0;
		r.st = ST_OK;
		kind_ok = (k != KIND_UNSET && k < KIND_LIMIT);
		ext_dropped = 0;
		case (op)
			OP_ADD: put_extent(b, l, k);
			OP_MARK: if (kind_ok) retype(b, l, k);
			OP_ALLOC: if (!take_free(l, page)) begin
				page = 0;
				r.st = ST_NO_SPACE;
			end
			OP_ALLOC_RES: begin
				te = SLOTS;
				if (kind_ok)
					for (int i = 0; i < SLOTS; i++)
						if (ext_kind[i] == KIND_RESERVE && ext_len[i] >= l) begin
							te = i;
							break;
						end
				if (te == SLOTS) begin
					r.st = ST_NO_RESERVE;
				end else begin
					page = ext_base[te];
					retype(page, l, k);
				end
			end
			OP_FREE: r.st = release_block(b);
			default: ;
		endcase
		if (ext_dropped && r.st == ST_OK)
			r.st = ST_TABLE_FULL;
		r.page = page[PNB-1:0];
		return r;
	endfunction

	function automatic dir_row_t row(logic [2:0] op, logic [PNB-1:0] b, logic [PNB-1:0] l,
			logic [3:0] k, bit typed = 0, logic [PNB-1:0] page = '0, st_code_t st = ST_OK);
		dir_row_t d;
		d.op = op; d.b = b; d.l = l; d.k = k;
		d.typed = typed; d.page = page; d.st = st;
		return d;
	endfunction

	task automatic report_mismatch(string what, longint got, longint want);
		$display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
		errors++;
	endtask

	// send one request; called and returns at a falling edge
	task automatic send_req(logic [2:0] op, logic [PNB-1:0] b, logic [PNB-1:0] l,
			logic [3:0] k, bit typed = 0, logic [PNB-1:0] page = '0, st_code_t st = ST_OK);
		int idle_pct;
		rsp_t r;
		idle_pct = (phase == 0) ? 31 : (phase == 1) ? 55 : 0;
		while ($urandom_range(99) < idle_pct) begin
			req_valid <= 1'b0;
			@(negedge clk);
		end
		req_valid <= 1'b1;
		operation <= op;
		base_page <= b;
		length <= l;
		kind <= k;
		@(posedge clk);
		while (!req_ready)
			@(posedge clk);
		r = predict_rsp(op, b, l, k);
		if ((op == OP_ALLOC || op == OP_ALLOC_RES) && r.st == ST_OK)
			taken_pages.push_back(r.page);
		if (typed) begin
			r.page = page;
			r.st = st;
		end
		pending_rsp.push_back(r);
		sent++;
		@(negedge clk);
	endtask

	// response checker
	always @(posedge clk) begin
		rsp_t want;
		if (arst_n && rsp_valid && rsp_ready) begin
			if (pending_rsp.size() == 0) begin
				report_mismatch("unexpected response", status, 0);
			end else begin
				want = pending_rsp.pop_front();
				if (result_page !== want.page)
					report_mismatch("result_page", result_page, want.page);
				if (status !== want.st)
					report_mismatch("status", status, want.st);
			end
		end
	end

	// receiver: random stalls per phase, one long hold-off
	initial begin
		int idle_pct;
		rsp_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (!hold_done && sent >= 300) begin
				hold_done = 1;
				hold_left = 600;
			end
			idle_pct = (phase == 0) ? 55 : (phase == 1) ? 31 : 0;
			if (hold_left > 0) begin
				hold_left--;
				rsp_ready <= 1'b0;
			end else begin
				rsp_ready <= ($urandom_range(99) >= idle_pct);
			end
		end
	end

	// watchdog on cycles without any accepted handshake
	always @(posedge clk) begin
		if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
			idle_cnt <= 0;
		else
			idle_cnt <= idle_cnt + 1;
		if (idle_cnt >= STALL_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	initial begin
		dir_row_t dir_tab[$];
		int pick;
		logic [2:0] op;
		logic [PNB-1:0] b, l;
		logic [3:0] k;

		arst_n = 1'b0;
		req_valid = 1'b0;
		operation = OP_ADD;
		base_page = '0;
		length = '0;
		kind = KIND_UNSET;
		for (int i = 0; i < SLOTS; i++) begin
			ext_kind[i] = KIND_UNSET;
			ext_base[i] = 0;
			ext_len[i] = 0;
		end
		cur_free = 0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		dir_tab = '{
			row(OP_FREE, 0, 0, KIND_UNSET, 1, 0, ST_NO_BLOCK),
			row(OP_ALLOC, 0, 5, KIND_FREE, 1, 0, ST_NO_SPACE),
			row(OP_ALLOC_RES, 0, 1, KIND_ALLOC, 1, 0, ST_NO_RESERVE),
			row(OP_ALLOC_RES, 0, 1, KIND_UNSET, 1, 0, ST_NO_RESERVE),
			row(OP_MARK, 10, 10, KIND_UNSET, 1, 0, ST_OK),
			row(OP_SPARE, PMAX, PMAX, 4'hf, 1, 0, ST_OK),
			row(OP_ADD, 10, 0, KIND_FREE, 1, 0, ST_OK),
			row(OP_ADD, 10, 5, 4'hf, 1, 0, ST_OK),
			row(OP_ADD, 100, 50, KIND_FREE),
			row(OP_ADD, 150, 20, KIND_FREE),
			row(OP_ALLOC, 0, 10, KIND_UNSET),
			row(OP_ALLOC, 0, 0, KIND_UNSET),
			row(OP_FREE, 105, 0, KIND_UNSET),
			row(OP_FREE, 100, 0, KIND_UNSET),
			row(OP_FREE, 100, 0, KIND_UNSET),
			row(OP_ADD, PMAX - PNB'(15), PMAX, KIND_RESERVE),
			row(OP_ALLOC_RES, 0, 4, KIND_ALLOC),
			row(OP_ALLOC_RES, 0, 100, KIND_ALLOC),
			row(OP_MARK, 120, 5, 4'd7),
			row(OP_MARK, 125, 5, 4'd7),
			row(OP_MARK, 1000, 8, 4'd3),
			row(OP_ALLOC, 0, PMAX, KIND_UNSET),
			row(OP_MARK, 0, PMAX, 4'd1),
			row(OP_ADD, 5000, 40, KIND_RESERVE),
			row(OP_ALLOC_RES, 0, 40, 4'd6)
		};
		@(negedge clk);
		foreach (dir_tab[i])
			send_req(dir_tab[i].op, dir_tab[i].b, dir_tab[i].l, dir_tab[i].k,
				dir_tab[i].typed, dir_tab[i].page, dir_tab[i].st);

		for (int n = 0; n < RAND_ITEMS; n++) begin
			phase = (n < RAND_ITEMS / 3) ? 0 : (n < 2 * RAND_ITEMS / 3) ? 1 : 2;
			pick = $urandom_range(99);
			// mostly a small page window so extents meet, split and merge
			b = ($urandom_range(19) == 0) ? PNB'($urandom) : PNB'($urandom_range(4095));
			l = ($urandom_range(19) == 0) ? PNB'($urandom) : PNB'($urandom_range(64));
			k = ($urandom_range(9) == 0) ? 4'($urandom_range(15)) : 4'($urandom_range(1, 9));
			if (pick < 22) begin
				op = OP_ADD;
				if ($urandom_range(2) == 0) k = KIND_FREE;
			end else if (pick < 37) begin
				op = OP_MARK;
			end else if (pick < 62) begin
				op = OP_ALLOC;
			end else if (pick < 72) begin
				op = OP_ALLOC_RES;
			end else if (pick < 95) begin
				op = OP_FREE;
				if (taken_pages.size() > 0 && $urandom_range(9) < 7) begin
					b = taken_pages[$urandom_range(taken_pages.size() - 1)];
					if ($urandom_range(3) == 0) b = b + PNB'(1);
				end
			end else begin
				op = 3'($urandom_range(OP_FREE + 1, OP_SPARE));
			end
			send_req(op, b, l, k);
		end
		req_valid <= 1'b0;

		while (pending_rsp.size() != 0)
			@(posedge clk);
		repeat (500) @(posedge clk);
		if (errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
